// ===== design/arw_pkg.sv =====
// ----------------------------------------------------------------------------
// arw_pkg
// shared types and codes of the anti-replay window block
// ----------------------------------------------------------------------------
package arw_pkg;

    typedef enum logic [1:0] {
        VERDICT_ADVANCED  = 2'd0,
        VERDICT_IN_WINDOW = 2'd1,
        VERDICT_TOO_OLD   = 2'd2,
        VERDICT_DUPLICATE = 2'd3
    } verdict_t;

    typedef enum logic [3:0] {
        ST_RESET,
        ST_INIT_SWEEP,
        ST_INIT_DRAIN,
        ST_IDLE,
        ST_COMPARE,
        ST_DIV_EST,
        ST_DIV_FIX,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_seq;
        logic     compare;
        logic     div_est;
        logic     div_fix;
        logic     sweep_init;
        logic     sweep_clear;
        logic     sweep_mark;
        logic     sweep_step;
        logic     read_word;
        logic     write_word;
        logic     update_high;
        logic     load_out;
        verdict_t verdict;
    } dp_cmd_t;

    typedef struct packed {
        logic newer;
        logic far;
        logic newer_held;
        logic sweep_last;
        logic bit_seen;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/anti_replay_window_core.sv =====
// ----------------------------------------------------------------------------
// anti_replay_window_core
// sliding-window anti-replay filter over a bitmap of recent sequence numbers
//
//   channel   signals                           direction   width
//   input     in_valid, in_ready, seq_number    in          32
//   result    out_valid, out_ready, accepted,   out         1 + 2
//             verdict
//
// one transaction in flight; from acceptance to out_valid an older number in
// the window goes through compare, divider, read, check and done, a too old
// number through compare and done, a newer one through compare, divider,
// slide and drain, a jump of the window size or more skipping the divider;
// the slide pipeline rewrites one bitmap word per cycle through the memory;
// in_ready returns in the same cycle as out_valid; after reset a clearing
// pass runs before in_ready rises; results wait in the output register, a
// new transaction is taken meanwhile and stalls in done only while it is full
// ----------------------------------------------------------------------------
module anti_replay_window_core
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = 1024,
    parameter int WORD_BITS   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] seq_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  verdict
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    arw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    arw_datapath #(
        .WINDOW_BITS (WINDOW_BITS),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_number (seq_number),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .accepted   (accepted),
        .verdict    (verdict)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken while one is in flight");

    a_no_accept_in_slide: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.sweep_step |-> !in_ready)
        else $error("input ready during bitmap rewrite");

    a_flag_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == ((verdict == VERDICT_ADVANCED) ||
                                    (verdict == VERDICT_IN_WINDOW))))
        else $error("accept flag disagrees with verdict");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten before it was taken");

endmodule

// ===== design/arw_datapath.sv =====
// ----------------------------------------------------------------------------
// arw_datapath
// highest-number register, offset split, bitmap memory, window slide
// pipeline and result register
// ----------------------------------------------------------------------------
module arw_datapath
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = 1024,
    parameter int WORD_BITS   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] seq_number,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        accepted,
    output logic [1:0]  verdict
);

    localparam int NUM_WORDS = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int IW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int XW        = $clog2(WINDOW_BITS);
    localparam int DIV_SHIFT = 20;
    localparam int PW        = XW + DIV_SHIFT;
    localparam int RECIP     = (1 << DIV_SHIFT) / WORD_BITS;
    localparam int TOP_REM   = WINDOW_BITS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] TOP_MASK = (TOP_REM == 0) ? {WORD_BITS{1'b1}} :
        WORD_BITS'((64'd1 << TOP_REM) - 64'd1);
    localparam logic [IW-1:0] LAST_WORD = IW'(NUM_WORDS - 1);

    logic [31:0]          seq_reg;
    logic [31:0]          high_reg;
    logic                 newer_held_reg;
    logic [XW-1:0]        x_reg;
    logic [XW-1:0]        qe_reg;
    logic [IW-1:0]        q_reg;
    logic [BW-1:0]        r_reg;
    logic [IW-1:0]        idx_reg;
    logic                 clear_reg;
    logic                 mark_reg;
    logic                 wb_valid_reg;
    logic [IW-1:0]        wb_idx_reg;
    logic                 hi_zero_reg;
    logic                 lo_zero_reg;
    logic [WORD_BITS-1:0] rd_hi_reg;
    logic [WORD_BITS-1:0] rd_lo_reg;
    logic                 out_valid_reg;
    logic                 accepted_reg;
    verdict_t             verdict_reg;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic                 newer;
    logic [31:0]          diff;
    logic                 far;
    logic [PW-1:0]        prod;
    logic [XW-1:0]        qe_next;
    logic [PW-1:0]        qb;
    logic [PW-1:0]        rem;
    logic                 fix;
    logic [XW-1:0]        q_full;
    logic [IW-1:0]        q_next;
    logic [BW-1:0]        r_next;
    logic [IW-1:0]        addr_hi;
    logic [IW-1:0]        addr_lo;
    logic                 hi_zero;
    logic                 lo_zero;
    logic [BW:0]          back_shift;
    logic [WORD_BITS-1:0] shifted_hi;
    logic [WORD_BITS-1:0] shifted_lo;
    logic [WORD_BITS-1:0] wb_data;
    logic [WORD_BITS-1:0] bit_mask;

    // compare against the highest number
    assign newer = seq_reg > high_reg;
    assign diff  = newer ? (seq_reg - high_reg) : (high_reg - seq_reg);
    assign far   = diff >= 32'(WINDOW_BITS);

    // split offset into word and bit by reciprocal multiply and one fixup
    assign prod    = PW'(x_reg) * PW'(RECIP);
    assign qe_next = prod[PW-1:DIV_SHIFT];
    assign qb      = PW'(qe_reg) * PW'(WORD_BITS);
    assign rem     = PW'(x_reg) - qb;
    assign fix     = rem >= PW'(WORD_BITS);
    assign q_full  = fix ? (qe_reg + XW'(1)) : qe_reg;
    assign q_next  = IW'(q_full);
    assign r_next  = fix ? BW'(rem - PW'(WORD_BITS)) : BW'(rem);

    // slide addresses, words below the shift read as zero
    assign addr_hi = cmd.read_word ? q_reg : (idx_reg - q_reg);
    assign addr_lo = idx_reg - q_reg - IW'(1);
    assign hi_zero = clear_reg || (idx_reg < q_reg);
    assign lo_zero = clear_reg || (r_reg == '0) ||
                     ({1'b0, idx_reg} < ({1'b0, q_reg} + (IW+1)'(1)));

    assign back_shift = (BW+1)'(WORD_BITS) - (BW+1)'(r_reg);
    assign shifted_hi = hi_zero_reg ? '0 : (rd_hi_reg << r_reg);
    assign shifted_lo = lo_zero_reg ? '0 : (rd_lo_reg >> back_shift);

    always_comb
    begin
        wb_data = shifted_hi | shifted_lo;
        if (wb_idx_reg == LAST_WORD)
        begin
            wb_data = wb_data & TOP_MASK;
        end
        if ((wb_idx_reg == '0) && mark_reg)
        begin
            wb_data[0] = 1'b1;
        end
    end

    assign bit_mask = WORD_BITS'(1) << r_reg;

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            mem[wb_idx_reg] <= wb_data;
        end
        else if (cmd.write_word)
        begin
            mem[q_reg] <= rd_hi_reg | bit_mask;
        end
        if (cmd.sweep_step || cmd.read_word)
        begin
            rd_hi_reg <= mem[addr_hi];
        end
        if (cmd.sweep_step)
        begin
            rd_lo_reg <= mem[addr_lo];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_seq)
        begin
            seq_reg <= seq_number;
        end
        if (cmd.compare)
        begin
            x_reg <= diff[XW-1:0];
        end
        if (cmd.div_est)
        begin
            qe_reg <= qe_next;
        end
        if (cmd.div_fix)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
        if (cmd.sweep_init)
        begin
            clear_reg <= cmd.sweep_clear;
            mark_reg  <= cmd.sweep_mark;
        end
        if (cmd.sweep_step)
        begin
            wb_idx_reg  <= idx_reg;
            hi_zero_reg <= hi_zero;
            lo_zero_reg <= lo_zero;
        end
        if (cmd.load_out)
        begin
            verdict_reg  <= cmd.verdict;
            accepted_reg <= (cmd.verdict == VERDICT_ADVANCED) ||
                            (cmd.verdict == VERDICT_IN_WINDOW);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg       <= '0;
            newer_held_reg <= 1'b0;
            idx_reg        <= '0;
            wb_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.update_high)
            begin
                high_reg <= seq_reg;
            end
            if (cmd.compare)
            begin
                newer_held_reg <= newer;
            end
            if (cmd.sweep_init)
            begin
                idx_reg <= LAST_WORD;
            end
            else if (cmd.sweep_step)
            begin
                idx_reg <= idx_reg - IW'(1);
            end
            wb_valid_reg <= cmd.sweep_step;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.newer      = newer;
    assign status.far        = far;
    assign status.newer_held = newer_held_reg;
    assign status.sweep_last = (idx_reg == '0);
    assign status.bit_seen   = rd_hi_reg[r_reg];
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign verdict   = verdict_reg;

endmodule

// ===== design/arw_ctrl.sv =====
// ----------------------------------------------------------------------------
// arw_ctrl
// sequencer for clearing, compare, offset split, window slide and check
// ----------------------------------------------------------------------------
module arw_ctrl
    import arw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t   state_reg;
    state_t   state_next;
    verdict_t verdict_reg;
    verdict_t verdict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RESET;
            verdict_reg <= VERDICT_ADVANCED;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            ST_RESET:
            begin
                state_next = ST_INIT_SWEEP;
            end
            ST_INIT_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_INIT_DRAIN;
                end
            end
            ST_INIT_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                if (status.newer && status.far)
                begin
                    verdict_next = VERDICT_ADVANCED;
                    state_next   = ST_SWEEP;
                end
                else if (status.far)
                begin
                    verdict_next = VERDICT_TOO_OLD;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV_EST;
                end
            end
            ST_DIV_EST:
            begin
                state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                if (status.newer_held)
                begin
                    verdict_next = VERDICT_ADVANCED;
                    state_next   = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                verdict_next = status.bit_seen ? VERDICT_DUPLICATE : VERDICT_IN_WINDOW;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_RESET;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        cmd.verdict = verdict_reg;
        in_ready    = 1'b0;
        case (state_reg)
            ST_RESET:
            begin
                cmd.sweep_init  = 1'b1;
                cmd.sweep_clear = 1'b1;
            end
            ST_INIT_SWEEP, ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_seq = in_valid;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                if (status.newer && status.far)
                begin
                    cmd.sweep_init  = 1'b1;
                    cmd.sweep_clear = 1'b1;
                    cmd.sweep_mark  = 1'b1;
                    cmd.update_high = 1'b1;
                end
            end
            ST_DIV_EST:
            begin
                cmd.div_est = 1'b1;
            end
            ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                if (status.newer_held)
                begin
                    cmd.sweep_init  = 1'b1;
                    cmd.sweep_mark  = 1'b1;
                    cmd.update_high = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.read_word = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.write_word = !status.bit_seen;
            end
            ST_DONE:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the anti-replay window core: sequence numbers are
// fed in bursts with random gaps while the result side stalls on its own
// pattern; a scoreboard keeps a shadow copy of the highest number and the
// window bitmap, predicts the verdict of every transaction and compares it
// with what the block returns, in order
// ----------------------------------------------------------------------------
module tb;
    import arw_pkg::*;

    localparam int WINDOW_BITS = 1024;
    localparam int WORD_BITS   = 64;
    localparam int NUM_PACKETS = 1350;

    typedef struct {
        logic [31:0] seq;
        logic        acc;
        verdict_t    verdict;
    } replay_result_t;

    class replay_scoreboard;
        logic [31:0]            top_seq;
        logic [WINDOW_BITS-1:0] window;
        replay_result_t         pending[$];
        int unsigned            mismatches;

        function new();
            top_seq    = '0;
            window     = '0;
            mismatches = 0;
        endfunction

        function void note_packet(logic [31:0] seq);
            replay_result_t r;
            logic [31:0]    gap;
            r.seq = seq;
            if (seq > top_seq)
            begin
                gap = seq - top_seq;
                if (gap >= WINDOW_BITS)
                    window = '0;
                else
                    window = window << gap;
                window[0] = 1'b1;
                top_seq   = seq;
                r.acc     = 1'b1;
                r.verdict = VERDICT_ADVANCED;
            end
            else
            begin
                gap = top_seq - seq;
                if (gap >= WINDOW_BITS)
                begin
                    r.acc     = 1'b0;
                    r.verdict = VERDICT_TOO_OLD;
                end
                else if (window[gap])
                begin
                    r.acc     = 1'b0;
                    r.verdict = VERDICT_DUPLICATE;
                end
                else
                begin
                    window[gap] = 1'b1;
                    r.acc       = 1'b1;
                    r.verdict   = VERDICT_IN_WINDOW;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_verdict(logic acc, logic [1:0] v);
            replay_result_t r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: accepted=%0b verdict=%0d", acc, v);
                return;
            end
            r = pending.pop_front();
            if (acc !== r.acc || v !== r.verdict)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch seq %h: expected %0b/%s, got %0b/%0d",
                             r.seq, r.acc, r.verdict.name(), acc, v);
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] seq_number = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        accepted;
    logic [1:0]  verdict;

    replay_scoreboard sb = new();
    bit               hold_req = 1'b0;

    anti_replay_window_core #(
        .WINDOW_BITS (WINDOW_BITS),
        .WORD_BITS   (WORD_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .seq_number (seq_number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .verdict    (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_verdict(accepted, verdict);
    end

    task automatic send_packet(input logic [31:0] seq);
        in_valid   <= 1'b1;
        seq_number <= seq;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_packet(seq);
    endtask

    task automatic idle_for(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_seq(input logic [31:0] hi);
        int unsigned r;
        logic [32:0] step;
        logic [31:0] back;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom;
        if (r < 25)
        begin
            case ($urandom_range(3))
                0: step = $urandom_range(8, 1);
                1: step = $urandom_range(70, 60);
                2: step = $urandom_range(1100, 1000);
                default: step = $urandom_range(200, 1);
            endcase
            step = step + hi;
            return step[32] ? 32'hFFFF_FFFF : step[31:0];
        end
        if (r < 55)
            back = $urandom_range(40, 0);
        else if (r < 85)
            back = $urandom_range(WINDOW_BITS - 1, 0);
        else if (r < 93)
            back = $urandom_range(WINDOW_BITS + 6, WINDOW_BITS - 4);
        else
            back = $urandom_range(100000, WINDOW_BITS);
        return (back > hi) ? 32'd0 : hi - back;
    endfunction

    // result side: stall pattern in segments, plus one long hold on request
    initial
    begin
        int unsigned ready_pct;
        int unsigned seg_len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            case ($urandom_range(3))
                0: ready_pct = 100;
                1: ready_pct = 70;
                2: ready_pct = 40;
                default: ready_pct = 90;
            endcase
            seg_len = $urandom_range(200, 30);
            repeat (seg_len)
            begin
                if (hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (400) @(posedge clk);
                    hold_req = 1'b0;
                end
                out_ready <= ($urandom_range(99) < ready_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned count;
        int unsigned burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero against reset highest, slides by 1, 63, 64, clears, window edges
        send_packet(32'd0);
        send_packet(32'd0);
        send_packet(32'd1);
        send_packet(32'd1);
        send_packet(32'd0);
        send_packet(32'd2000);
        send_packet(32'd977);
        send_packet(32'd977);
        send_packet(32'd976);
        send_packet(32'd2001);
        send_packet(32'd2064);
        send_packet(32'd2128);
        send_packet(32'd2129);
        send_packet(32'd1106);
        send_packet(32'd0);
        idle_for($urandom_range(20, 1));

        count = 0;
        while (count < NUM_PACKETS)
        begin
            burst = $urandom_range(24, 1);
            repeat (burst)
            begin
                send_packet(pick_seq(sb.top_seq));
                count++;
                if (count == 400)
                begin
                    hold_req = 1'b1;
                    repeat (12)
                    begin
                        send_packet(pick_seq(sb.top_seq));
                        count++;
                    end
                end
                if (count == 800)
                    wait_drained();
            end
            if ($urandom_range(3) != 0)
                idle_for($urandom_range(25, 1));
        end

        // top of the number range, no wraparound
        send_packet(32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF);
        send_packet(32'hFFFF_FC00);
        send_packet(32'hFFFF_FBFF);
        send_packet(32'd0);
        send_packet(32'hFFFF_FFFE);

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
